// ----- rtl/vyuyrgb_pkg.sv -----
package vyuyrgb_pkg;

    // configuration register fields
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int ROW_W       = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int DEF_MAX_WIDTH = 4096;

    // reset values of the frame geometry
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_WIDTH  = 13'd1280;
    localparam logic [CFG_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd720;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // round, floor shift by 8 and clamp to 0..255
    function automatic logic [7:0] clamp_shift(input logic signed [19:0] acc);
        logic [7:0] res;
        if (acc[19])
            res = 8'd0;
        else if (acc[18:16] != 3'd0)
            res = 8'd255;
        else
            res = acc[15:8];
        return res;
    endfunction

    // bt.601 integer conversion of one pixel
    function automatic rgb_t convert(input logic [7:0] y, input logic [7:0] u,
                                     input logic [7:0] v);
        logic signed [9:0]  c;
        logic signed [9:0]  d;
        logic signed [9:0]  e;
        logic signed [19:0] luma_term;
        logic signed [19:0] acc_r;
        logic signed [19:0] acc_g;
        logic signed [19:0] acc_b;
        rgb_t               px;
        c = $signed({2'b00, y}) - 10'sd16;
        d = $signed({2'b00, u}) - 10'sd128;
        e = $signed({2'b00, v}) - 10'sd128;
        luma_term = 20'sd298 * 20'(c) + 20'sd128;
        acc_r = luma_term + 20'sd409 * 20'(e);
        acc_g = luma_term - 20'sd100 * 20'(d) - 20'sd208 * 20'(e);
        acc_b = luma_term + 20'sd516 * 20'(d);
        px.red   = clamp_shift(acc_r);
        px.green = clamp_shift(acc_g);
        px.blue  = clamp_shift(acc_b);
        return px;
    endfunction

endpackage

// ----- rtl/vyuy_to_rgb32_line_decimate.sv -----
// VYUY macropixel stream to BGR pixel pairs with 2:1 vertical decimation.
// One macropixel is taken per transfer on the s_ side; items on odd lines of
// the frame are consumed and give nothing, items on even lines give one pixel
// pair on the m_ side with BT.601 conversion (alpha 0xff implied). Throughput
// is one item per cycle while m_tready does not stall the output; an item
// passes the input register, then conversion into the output register (m_tvalid).
// m_tlast marks the last macropixel of a kept line, m_tuser the last result
// of the frame. A configuration write restarts the frame at line 0, column 0;
// write only while no item is in flight. cfg_ready is always high.
module vyuy_to_rgb32_line_decimate #(
    parameter int MAX_WIDTH = vyuyrgb_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vyuyrgb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vyuyrgb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // chroma_v[7:0], luma_first[15:8], chroma_u[23:16], luma_second[31:24]
    input  logic [vyuyrgb_pkg::S_DATA_W-1:0]     s_tdata,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // blue_first[7:0], green_first[15:8], red_first[23:16],
    // blue_second[31:24], green_second[39:32], red_second[47:40]
    output logic [vyuyrgb_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast,  // line_end
    output logic                                 m_tuser   // frame_end
);
    import vyuyrgb_pkg::*;

    localparam int MaxPerLine = (MAX_WIDTH + 1) / 2;
    localparam int ColW       = (MaxPerLine > 1) ? $clog2(MaxPerLine) : 1;
    localparam int DimW       = CFG_DATA_W + 1;

    logic [CFG_DATA_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_DATA_W-1:0] frame_height_reg, frame_height_next;
    logic [ColW-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [S_DATA_W-1:0]   s1_data_reg;
    logic                  s1_last_reg;
    logic                  s1_frame_end_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    logic                  cfg_write;
    logic                  in_xfer;
    logic                  s1_move;
    logic [DimW-1:0]       width_eff;
    logic [DimW-1:0]       per_line;
    logic [DimW-1:0]       last_col;
    logic [CFG_DATA_W-1:0] height_eff;
    logic [ROW_W-1:0]      last_row;
    logic [ROW_W-1:0]      last_kept;
    logic                  at_line_end;
    logic                  at_frame_end;
    logic                  kept;
    rgb_t                  px_first;
    rgb_t                  px_second;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // pipeline handshakes
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign in_xfer  = s_tvalid && s_tready;

    // effective frame geometry
    always_comb
    begin
        if (frame_width_reg < CFG_DATA_W'(2))
            width_eff = DimW'(2);
        else if ({1'b0, frame_width_reg} > DimW'(MAX_WIDTH))
            width_eff = DimW'(MAX_WIDTH);
        else
            width_eff = {1'b0, frame_width_reg};
        per_line = (width_eff + DimW'(1)) >> 1;
        last_col = per_line - DimW'(1);

        if (frame_height_reg == '0)
            height_eff = CFG_DATA_W'(1);
        else if (frame_height_reg > CFG_DATA_W'(MAX_HEIGHT))
            height_eff = CFG_DATA_W'(MAX_HEIGHT);
        else
            height_eff = frame_height_reg;
        last_row  = ROW_W'(height_eff - CFG_DATA_W'(1));
        last_kept = last_row & ~ROW_W'(1);

        at_line_end  = DimW'(col_reg) >= last_col;
        at_frame_end = row_reg >= last_row;
        kept         = !row_reg[0];
    end

    // configuration registers and frame position counters
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:          ;
            endcase
            col_next = '0;
            row_next = '0;
        end
        else if (in_xfer)
        begin
            if (at_line_end)
            begin
                col_next = '0;
                row_next = at_frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ColW'(1);
            end
        end
    end

    // stage valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = kept;
        else if (s1_move)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (s1_move)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            s1_valid_reg     <= s1_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // input register with line and frame marks
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg      <= s_tdata;
            s1_last_reg      <= at_line_end;
            s1_frame_end_reg <= at_line_end && (row_reg >= last_kept);
        end
    end

    // color conversion of both pixels
    always_comb
    begin
        px_first  = convert(s1_data_reg[15:8], s1_data_reg[23:16], s1_data_reg[7:0]);
        px_second = convert(s1_data_reg[31:24], s1_data_reg[23:16], s1_data_reg[7:0]);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_data_reg <= {px_second.red, px_second.green, px_second.blue,
                           px_first.red, px_first.green, px_first.blue};
            m_last_reg <= s1_last_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- rtl/vyuyrgb_sva.sv -----
module vyuyrgb_sva (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [vyuyrgb_pkg::M_DATA_W-1:0]     m_tdata,
    input logic                                 m_tlast,
    input logic                                 m_tuser
);
    import vyuyrgb_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result changed");

    // the frame end mark only comes on the last item of a line
    a_frame_end_on_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without line end");

    // input only backs up when a result is held by the sink
    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output is free");

    // configuration writes are never refused
    a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind vyuy_to_rgb32_line_decimate vyuyrgb_sva u_vyuyrgb_sva (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);

// ----- tb/tb_vyuy_to_rgb32_line_decimate.sv -----
module tb_vyuy_to_rgb32_line_decimate;
    import vyuyrgb_pkg::*;

    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1300;
    localparam int TIMEOUT      = 30_000_000;

    // one macropixel as it travels on s_tdata, chroma_v in the lowest byte
    typedef struct packed {
        logic [7:0] luma_second;
        logic [7:0] chroma_u;
        logic [7:0] luma_first;
        logic [7:0] chroma_v;
    } macropixel_t;

    // one pixel pair as {m_tuser, m_tlast, m_tdata}, blue_first in the lowest byte
    typedef struct packed {
        logic       frame_end;
        logic       line_end;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
    } pixel_pair_t;

    typedef struct {
        logic [31:0] stim;
        bit          typed;
        logic [49:0] want;
    } directed_row_t;

    typedef struct {
        int width;
        int height;
        int write_mask;
        int items;
    } frame_setting_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // shadow of the frame geometry and position
    logic [CFG_DATA_W-1:0]  geo_width  = RESET_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  geo_height = RESET_FRAME_HEIGHT;
    logic [10:0]            col_pos    = '0;
    logic [11:0]            row_pos    = '0;

    pixel_pair_t            pair_queue [$];
    int                     error_count   = 0;
    int                     items_sent    = 0;
    int                     pairs_checked = 0;
    int                     setting_count = 0;
    bit                     sender_gaps   = 1'b1;

    string field_names [8] = '{"blue_first", "green_first", "red_first", "blue_second",
                               "green_second", "red_second", "line_end", "frame_end"};

    // extremes of the fields; all-black and all-white rows are typed in
    directed_row_t directed_rows [16] = '{
        '{32'h0080_0080, 1'b1, 50'h0_0000_0000_0000},
        '{32'hFF80_FF80, 1'b1, 50'h0_FFFF_FFFF_FFFF},
        '{32'hFF80_0080, 1'b1, 50'h0_FFFF_FF00_0000},
        '{32'hEB80_1080, 1'b1, 50'h0_FFFF_FF00_0000},
        '{32'h0000_0000, 1'b0, 50'h0},
        '{32'hFFFF_FFFF, 1'b0, 50'h0},
        '{32'h00FF_FF00, 1'b0, 50'h0},
        '{32'hFF00_00FF, 1'b0, 50'h0},
        '{32'hEBFF_1000, 1'b0, 50'h0},
        '{32'h1000_EBFF, 1'b0, 50'h0},
        '{32'h5555_AAAA, 1'b0, 50'h0},
        '{32'hAAAA_5555, 1'b0, 50'h0},
        '{32'h0180_8001, 1'b0, 50'h0},
        '{32'h8001_0180, 1'b0, 50'h0},
        '{32'h7F80_8080, 1'b0, 50'h0},
        '{32'h80EB_7F10, 1'b0, 50'h0}
    };

    // geometry corners: decimation, clamps, odd width, restart mid-frame
    frame_setting_t frame_plan [9] = '{
        '{4,    3,    3, 10},
        '{0,    0,    3, 6},
        '{1,    2,    3, 8},
        '{5,    4,    3, 26},
        '{6,    5,    3, 7},
        '{6,    5,    2, 20},
        '{6,    6,    1, 20},
        '{8191, 1,    3, 40},
        '{0,    8191, 3, 40}
    };

    vyuy_to_rgb32_line_decimate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT;
        $display("%0t: timeout with %0d pixel pairs outstanding", $time, pair_queue.size());
        $display("** vyuy_to_rgb32_line_decimate: FAILED **");
        $finish;
    end

    // round, floor shift by 8 and saturate
    function automatic logic [7:0] saturate_byte(input int acc);
        if (acc < 0)
            return 8'd0;
        if ((acc >>> 8) > 255)
            return 8'd255;
        return 8'(acc >>> 8);
    endfunction

    // bt.601 integer conversion, returned as {red, green, blue}
    function automatic logic [23:0] ycbcr_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                                 input logic [7:0] v);
        int c;
        int d;
        int e;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        return {saturate_byte(298 * c + 409 * e + 128),
                saturate_byte(298 * c - 100 * d - 208 * e + 128),
                saturate_byte(298 * c + 516 * d + 128)};
    endfunction

    // expected pair for one macropixel, advancing the frame position
    task automatic decimate_and_convert(input macropixel_t mp, output bit kept,
                                        output pixel_pair_t pair);
        int w;
        int h;
        int per_line;
        int last_kept;
        bit at_line_end;
        bit at_frame_end;
        w = geo_width;
        h = geo_height;
        if (w < 2)
            w = 2;
        if (w > DEF_MAX_WIDTH)
            w = DEF_MAX_WIDTH;
        if (h < 1)
            h = 1;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        per_line     = (w + 1) / 2;
        last_kept    = (h - 1) & ~1;
        at_line_end  = int'(col_pos) >= per_line - 1;
        at_frame_end = int'(row_pos) >= h - 1;
        kept         = !row_pos[0];
        pair = {at_line_end && int'(row_pos) >= last_kept, at_line_end,
                ycbcr_to_rgb(mp.luma_second, mp.chroma_u, mp.chroma_v),
                ycbcr_to_rgb(mp.luma_first, mp.chroma_u, mp.chroma_v)};
        if (at_line_end)
        begin
            col_pos = '0;
            row_pos = at_frame_end ? 12'd0 : row_pos + 12'd1;
        end
        else
        begin
            col_pos = col_pos + 11'd1;
        end
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [5] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd255};
        if ($urandom_range(0, 4) == 0)
            return corners[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    // one input transfer; valid stays high when the next item follows at once
    task automatic send_macropixel(input macropixel_t mp, input bit typed,
                                   input pixel_pair_t typed_pair);
        int gap;
        int r;
        bit kept;
        pixel_pair_t pair;
        gap = 0;
        r = $urandom_range(0, 99);
        if (sender_gaps && r >= 55)
            gap = (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mp;
        do @(posedge clk); while (!s_tready);
        decimate_and_convert(mp, kept, pair);
        if (kept)
            pair_queue.push_back(typed ? typed_pair : pair);
        items_sent++;
    endtask

    // hold the input until every pending pair has been seen
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pair_queue.size() != 0);
    endtask

    task automatic wait_idle();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (index == REG_FRAME_WIDTH)
            geo_width = value;
        else
            geo_height = value;
        col_pos = '0;
        row_pos = '0;
    endtask

    // new geometry, then a run of random macropixels
    task automatic run_frame_setting(input frame_setting_t fs);
        int pause_at;
        wait_idle();
        if (fs.write_mask[0])
            write_register(REG_FRAME_WIDTH, CFG_DATA_W'(fs.width));
        if (fs.write_mask[1])
            write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(fs.height));
        cfg_valid <= 1'b0;
        setting_count++;
        sender_gaps = $urandom_range(0, 3) != 0;
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, fs.items - 1) : -1;
        for (int i = 0; i < fs.items; i++)
        begin
            if (i == pause_at)
                pause_until_drained();
            send_macropixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()}, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // output side: random ready with stalls mostly short, some long, some none
    initial
    begin
        int run;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (run > 0)
            begin
                run--;
            end
            else if (m_tready)
            begin
                m_tready <= 1'b0;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 8);
            end
        end
    end

    // compare each output transfer against the oldest expected pair
    always @(posedge clk)
    begin : check_pairs
        pixel_pair_t got;
        pixel_pair_t want;
        logic [7:0]  got_field;
        logic [7:0]  want_field;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tlast, m_tdata};
            if (pair_queue.size() == 0)
            begin
                $display("%0t: unexpected pixel pair %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pair_queue.pop_front();
                pairs_checked++;
                for (int i = 0; i < 8; i++)
                begin
                    got_field  = (i < 6) ? got[i*8 +: 8] : {7'd0, got[42 + i]};
                    want_field = (i < 6) ? want[i*8 +: 8] : {7'd0, want[42 + i]};
                    if (got_field !== want_field)
                    begin
                        $display("%0t: %s expected %h actual %h", $time, field_names[i],
                                 want_field, got_field);
                        error_count++;
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        frame_setting_t fs;
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset geometry, with one full drain halfway
        foreach (directed_rows[i])
        begin
            if (i == 8)
                pause_until_drained();
            send_macropixel(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        end
        s_tvalid <= 1'b0;

        foreach (frame_plan[i])
            run_frame_setting(frame_plan[i]);

        // random geometries, mostly small
        while (items_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                fs.width = $urandom_range(0, 12);
            else if (r < 96)
                fs.width = $urandom_range(13, 80);
            else
                fs.width = 4095 + $urandom_range(0, 2) + (($urandom_range(0, 3) == 0) ? 4094 : 0);
            r = $urandom_range(0, 99);
            if (r < 85)
                fs.height = $urandom_range(0, 6);
            else if (r < 97)
                fs.height = $urandom_range(7, 40);
            else
                fs.height = 4096 + $urandom_range(0, 1) + (($urandom_range(0, 1) == 0) ? 4094 : 0);
            fs.write_mask = $urandom_range(0, 3);
            fs.items      = $urandom_range(10, 100);
            run_frame_setting(fs);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("run covered %0d macropixels over %0d geometry settings", items_sent,
                 setting_count);
        $display("checked %0d pixel pairs, %0d mismatches", pairs_checked, error_count);
        if (error_count == 0)
            $display("** vyuy_to_rgb32_line_decimate: PASSED **");
        else
            $display("** vyuy_to_rgb32_line_decimate: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vyuyrgb_pkg.sv
rtl/vyuy_to_rgb32_line_decimate.sv
rtl/vyuyrgb_sva.sv
tb/tb_vyuy_to_rgb32_line_decimate.sv
